[sv/efcs_pkg.sv]
package efcs_pkg;

  // Largest frame length that is counted; bytes past it are dropped.
  localparam int MAX_FRAME = 1518;
  localparam int LEN_W     = 11;

  // Request kinds on the input side and result kinds on the output side.
  localparam logic REQ_BYTE     = 1'b0;
  localparam logic REQ_READ     = 1'b1;
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_COUNTER = 1'b1;

  // Frame classes.
  localparam logic [1:0] FC_OTHER = 2'd0;
  localparam logic [1:0] FC_ARP   = 2'd1;
  localparam logic [1:0] FC_IPV4  = 2'd2;
  localparam logic [1:0] FC_IPV6  = 2'd3;

  // Layer 4 classes.
  localparam logic [2:0] L4_NONE    = 3'd0;
  localparam logic [2:0] L4_ICMP    = 3'd1;
  localparam logic [2:0] L4_UDP     = 3'd2;
  localparam logic [2:0] L4_TCP     = 3'd3;
  localparam logic [2:0] L4_ICMP6   = 3'd4;
  localparam logic [2:0] L4_ROUTING = 3'd5;
  localparam logic [2:0] L4_OTHER   = 3'd6;

  // Message kinds.
  localparam logic [1:0] MK_NONE    = 2'd0;
  localparam logic [1:0] MK_REQUEST = 2'd1;
  localparam logic [1:0] MK_REPLY   = 2'd2;

  // Application classes by destination port.
  localparam logic [2:0] APP_NONE  = 3'd0;
  localparam logic [2:0] APP_DNS   = 3'd1;
  localparam logic [2:0] APP_DHCP  = 3'd2;
  localparam logic [2:0] APP_HTTP  = 3'd3;
  localparam logic [2:0] APP_HTTPS = 3'd4;

  // Header constants.
  localparam logic [15:0] ET_ARP        = 16'h0806;
  localparam logic [15:0] ET_IPV4       = 16'h0800;
  localparam logic [7:0]  ET_IPV6_HI    = 8'h86;
  localparam logic [7:0]  ET_IPV6_LO    = 8'hdd;
  localparam logic [15:0] ET_IPV6       = {ET_IPV6_HI, ET_IPV6_LO};
  localparam logic [7:0]  IPP_ICMP      = 8'd1;
  localparam logic [7:0]  IPP_TCP       = 8'd6;
  localparam logic [7:0]  IPP_UDP       = 8'd17;
  localparam logic [7:0]  IPP_ROUTING   = 8'd43;
  localparam logic [7:0]  IPP_ICMP6     = 8'd58;
  localparam logic [15:0] ARP_OP_REQ    = 16'd1;
  localparam logic [15:0] ARP_OP_REP    = 16'd2;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REP = 8'd0;
  localparam logic [7:0]  ICMP6_ECHO_REQ = 8'h80;
  localparam logic [7:0]  ICMP6_ECHO_REP = 8'h81;
  localparam logic [15:0] PORT_DNS      = 16'd53;
  localparam logic [15:0] PORT_DHCP_SRV = 16'd67;
  localparam logic [15:0] PORT_DHCP_CLI = 16'd68;
  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_HTTPS    = 16'd443;
  localparam logic [6:0]  IPV6_L4_OFS   = 7'd54;
  localparam logic [6:0]  IPV4_HDR_OFS  = 7'd14;

  // Byte positions of the captured header bytes.
  localparam logic [LEN_W-1:0] POS_ET_HI = 11'd12;
  localparam logic [LEN_W-1:0] POS_ET_LO = 11'd13;
  localparam logic [LEN_W-1:0] POS_VIHL  = 11'd14;
  localparam logic [LEN_W-1:0] POS_B20   = 11'd20;
  localparam logic [LEN_W-1:0] POS_B21   = 11'd21;
  localparam logic [LEN_W-1:0] POS_B23   = 11'd23;

  // Protocol counter indexes in the counter memory.
  localparam int NUM_PCOUNT = 17;
  localparam int PC_AW      = 5;
  localparam int CI_IPV4      = 0;
  localparam int CI_IPV6      = 1;
  localparam int CI_ARP       = 2;
  localparam int CI_ARP_REQ   = 3;
  localparam int CI_ARP_REP   = 4;
  localparam int CI_ICMP      = 5;
  localparam int CI_ICMP_REQ  = 6;
  localparam int CI_ICMP_REP  = 7;
  localparam int CI_ICMP6     = 8;
  localparam int CI_ICMP6_REQ = 9;
  localparam int CI_ICMP6_REP = 10;
  localparam int CI_UDP       = 11;
  localparam int CI_TCP       = 12;
  localparam int CI_DNS       = 13;
  localparam int CI_DHCP      = 14;
  localparam int CI_HTTP      = 15;
  localparam int CI_HTTPS     = 16;

  // Counter read indexes as seen on the request side.
  localparam logic [4:0] RI_FRAMES     = 5'd0;
  localparam logic [4:0] RI_BYTES      = 5'd1;
  localparam logic [4:0] RI_MAX        = 5'd2;
  localparam logic [4:0] RI_MIN        = 5'd3;
  localparam logic [4:0] RI_PROTO_BASE = 5'd4;
  localparam logic [4:0] RI_PROTO_LAST = 5'(int'(RI_PROTO_BASE) + NUM_PCOUNT - 1);

  // Pending increments per counter; the drain pointer visits every entry
  // in turn, so a delta stays at or below NUM_PCOUNT and a
  // delta plus an in-flight snapshot stays at or below twice that.
  localparam int DELTA_W = $clog2(2 * NUM_PCOUNT + 1);

  localparam int RV_W = 48;

  typedef struct packed {
    logic [1:0]       frame_class;
    logic [2:0]       l4_class;
    logic [1:0]       msg_kind;
    logic [15:0]      source_port;
    logic [15:0]      dest_port;
    logic [2:0]       app_class;
    logic [LEN_W-1:0] frame_length;
  } summary_t;

  typedef struct packed {
    logic             rd_en;
    logic [PC_AW-1:0] rd_addr;
  } ctr_req_t;

endpackage

[sv/efcs_parser.sv]
module efcs_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_en,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output efcs_pkg::summary_t          summary,
  output logic [efcs_pkg::NUM_PCOUNT-1:0] bump
);

  localparam int LW = efcs_pkg::LEN_W;

  logic [LW-1:0] pos_r;
  logic [6:0]    l4_ofs_r;
  logic [7:0]    et_hi_r, et_lo_r, b20_r, b21_r, b23_r;
  logic [7:0]    l4b_r [4];

  logic [7:0]    et_hi_nxt, et_lo_nxt, b20_nxt, b21_nxt, b23_nxt;
  logic [7:0]    l4b_nxt [4];
  logic [6:0]    l4_ofs_nxt;
  logic [6:0]    l4_eff;
  logic [LW-1:0] l4_diff;
  logic          pos_ok, cap, in_l4;
  logic [LW-1:0] pos_nxt;

  assign pos_ok = pos_r < LW'(efcs_pkg::MAX_FRAME);
  assign cap    = byte_en && pos_ok;
  assign pos_nxt = pos_ok ? pos_r + LW'(1) : pos_r;

  // The L4 offset is fixed for IPv6 and follows the IHL nibble otherwise.
  always_comb begin
    l4_ofs_nxt = l4_ofs_r;
    if (cap && pos_r == efcs_pkg::POS_VIHL) begin
      if (et_hi_r == efcs_pkg::ET_IPV6_HI && et_lo_r == efcs_pkg::ET_IPV6_LO) begin
        l4_ofs_nxt = efcs_pkg::IPV6_L4_OFS;
      end else begin
        l4_ofs_nxt = 7'({data_byte[3:0], 2'b00}) + efcs_pkg::IPV4_HDR_OFS;
      end
    end
  end

  assign l4_eff  = (pos_r == efcs_pkg::POS_VIHL) ? l4_ofs_nxt : l4_ofs_r;
  assign l4_diff = pos_r - LW'(l4_eff);
  assign in_l4   = (pos_r >= efcs_pkg::POS_VIHL) && (pos_r >= LW'(l4_eff)) &&
                   (l4_diff < LW'(4));

  always_comb begin
    et_hi_nxt = (cap && pos_r == efcs_pkg::POS_ET_HI) ? data_byte : et_hi_r;
    et_lo_nxt = (cap && pos_r == efcs_pkg::POS_ET_LO) ? data_byte : et_lo_r;
    b20_nxt   = (cap && pos_r == efcs_pkg::POS_B20)   ? data_byte : b20_r;
    b21_nxt   = (cap && pos_r == efcs_pkg::POS_B21)   ? data_byte : b21_r;
    b23_nxt   = (cap && pos_r == efcs_pkg::POS_B23)   ? data_byte : b23_r;
    for (int k = 0; k < 4; k++) begin
      l4b_nxt[k] = (cap && in_l4 && l4_diff[1:0] == 2'(k)) ? data_byte : l4b_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      l4_ofs_r <= '0;
      et_hi_r  <= '0;
      et_lo_r  <= '0;
      b20_r    <= '0;
      b21_r    <= '0;
      b23_r    <= '0;
      for (int k = 0; k < 4; k++) l4b_r[k] <= '0;
    end else if (byte_en) begin
      if (last_byte) begin
        pos_r    <= '0;
        l4_ofs_r <= '0;
        et_hi_r  <= '0;
        et_lo_r  <= '0;
        b20_r    <= '0;
        b21_r    <= '0;
        b23_r    <= '0;
        for (int k = 0; k < 4; k++) l4b_r[k] <= '0;
      end else begin
        pos_r    <= pos_nxt;
        l4_ofs_r <= l4_ofs_nxt;
        et_hi_r  <= et_hi_nxt;
        et_lo_r  <= et_lo_nxt;
        b20_r    <= b20_nxt;
        b21_r    <= b21_nxt;
        b23_r    <= b23_nxt;
        for (int k = 0; k < 4; k++) l4b_r[k] <= l4b_nxt[k];
      end
    end
  end

  // Classification sees the header including the byte being taken now.
  always_comb begin
    logic [15:0] et, op, sp, dp;
    logic        is_udp, is_tcp;
    et     = {et_hi_nxt, et_lo_nxt};
    op     = {b20_nxt, b21_nxt};
    sp     = {l4b_nxt[0], l4b_nxt[1]};
    dp     = {l4b_nxt[2], l4b_nxt[3]};
    is_udp = 1'b0;
    is_tcp = 1'b0;
    summary = '0;
    bump    = '0;
    summary.frame_length = pos_nxt;
    if (et == efcs_pkg::ET_ARP) begin
      bump[efcs_pkg::CI_ARP] = 1'b1;
      summary.frame_class = efcs_pkg::FC_ARP;
      if (op == efcs_pkg::ARP_OP_REQ) begin
        summary.msg_kind = efcs_pkg::MK_REQUEST;
        bump[efcs_pkg::CI_ARP_REQ] = 1'b1;
      end else if (op == efcs_pkg::ARP_OP_REP) begin
        summary.msg_kind = efcs_pkg::MK_REPLY;
        bump[efcs_pkg::CI_ARP_REP] = 1'b1;
      end
    end else if (et == efcs_pkg::ET_IPV4) begin
      bump[efcs_pkg::CI_IPV4] = 1'b1;
      summary.frame_class = efcs_pkg::FC_IPV4;
      if (b23_nxt == efcs_pkg::IPP_ICMP) begin
        bump[efcs_pkg::CI_ICMP] = 1'b1;
        summary.l4_class = efcs_pkg::L4_ICMP;
        if (l4b_nxt[0] == efcs_pkg::ICMP_ECHO_REQ) begin
          summary.msg_kind = efcs_pkg::MK_REQUEST;
          bump[efcs_pkg::CI_ICMP_REQ] = 1'b1;
        end else if (l4b_nxt[0] == efcs_pkg::ICMP_ECHO_REP) begin
          summary.msg_kind = efcs_pkg::MK_REPLY;
          bump[efcs_pkg::CI_ICMP_REP] = 1'b1;
        end
      end else if (b23_nxt == efcs_pkg::IPP_UDP) begin
        is_udp = 1'b1;
      end else if (b23_nxt == efcs_pkg::IPP_TCP) begin
        is_tcp = 1'b1;
      end else begin
        summary.l4_class = efcs_pkg::L4_OTHER;
      end
    end else if (et == efcs_pkg::ET_IPV6) begin
      bump[efcs_pkg::CI_IPV6] = 1'b1;
      summary.frame_class = efcs_pkg::FC_IPV6;
      if (b20_nxt == efcs_pkg::IPP_UDP) begin
        is_udp = 1'b1;
      end else if (b20_nxt == efcs_pkg::IPP_TCP) begin
        is_tcp = 1'b1;
      end else if (b20_nxt == efcs_pkg::IPP_ICMP6) begin
        bump[efcs_pkg::CI_ICMP6] = 1'b1;
        summary.l4_class = efcs_pkg::L4_ICMP6;
        if (l4b_nxt[0] == efcs_pkg::ICMP6_ECHO_REQ) begin
          summary.msg_kind = efcs_pkg::MK_REQUEST;
          bump[efcs_pkg::CI_ICMP6_REQ] = 1'b1;
        end else if (l4b_nxt[0] == efcs_pkg::ICMP6_ECHO_REP) begin
          summary.msg_kind = efcs_pkg::MK_REPLY;
          bump[efcs_pkg::CI_ICMP6_REP] = 1'b1;
        end
      end else if (b20_nxt == efcs_pkg::IPP_ROUTING) begin
        summary.l4_class = efcs_pkg::L4_ROUTING;
      end else begin
        summary.l4_class = efcs_pkg::L4_OTHER;
      end
    end

    if (is_udp || is_tcp) begin
      summary.source_port = sp;
      summary.dest_port   = dp;
    end
    if (is_udp) begin
      bump[efcs_pkg::CI_UDP] = 1'b1;
      summary.l4_class = efcs_pkg::L4_UDP;
      if (dp == efcs_pkg::PORT_DNS) begin
        summary.app_class = efcs_pkg::APP_DNS;
        bump[efcs_pkg::CI_DNS] = 1'b1;
      end else if (dp == efcs_pkg::PORT_DHCP_SRV || dp == efcs_pkg::PORT_DHCP_CLI) begin
        summary.app_class = efcs_pkg::APP_DHCP;
        bump[efcs_pkg::CI_DHCP] = 1'b1;
      end
    end
    if (is_tcp) begin
      bump[efcs_pkg::CI_TCP] = 1'b1;
      summary.l4_class = efcs_pkg::L4_TCP;
      if (dp == efcs_pkg::PORT_HTTP) begin
        summary.app_class = efcs_pkg::APP_HTTP;
        bump[efcs_pkg::CI_HTTP] = 1'b1;
      end else if (dp == efcs_pkg::PORT_HTTPS) begin
        summary.app_class = efcs_pkg::APP_HTTPS;
        bump[efcs_pkg::CI_HTTPS] = 1'b1;
      end else if (dp == efcs_pkg::PORT_DNS) begin
        summary.app_class = efcs_pkg::APP_DNS;
        bump[efcs_pkg::CI_DNS] = 1'b1;
      end
    end
  end

endmodule

[sv/efcs_counters.sv]
module efcs_counters (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [efcs_pkg::NUM_PCOUNT-1:0] bump,
  input  efcs_pkg::ctr_req_t              req,
  output logic [31:0]                     rd_value
);

  localparam int N  = efcs_pkg::NUM_PCOUNT;
  localparam int AW = efcs_pkg::PC_AW;
  localparam int DW = efcs_pkg::DELTA_W;

  // Counter memory: one write port, two read ports (drain and host read).
  logic [31:0]   mem [N];
  logic [N-1:0]  valid_r;

  logic [DW-1:0] delta_r [N];
  logic [AW-1:0] dr_ptr_r;
  logic [AW-1:0] wr_addr_r;
  logic          wr_pend_r;
  logic [31:0]   dr_q_r;
  logic [DW-1:0] snap_r;
  logic [31:0]   rd_q_r;
  logic [DW-1:0] extra_r;
  logic [AW-1:0] dr_ptr_nxt;

  assign dr_ptr_nxt = (dr_ptr_r == AW'(N - 1)) ? '0 : dr_ptr_r + AW'(1);

  // Drain: read entry at the pointer and take its pending delta; in the next
  // cycle write the sum back. Pending deltas absorb new increments meanwhile.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dr_ptr_r  <= '0;
      wr_pend_r <= 1'b0;
      valid_r   <= '0;
      for (int i = 0; i < N; i++) delta_r[i] <= '0;
    end else begin
      dr_ptr_r  <= dr_ptr_nxt;
      wr_pend_r <= 1'b1;
      if (wr_pend_r) valid_r[wr_addr_r] <= 1'b1;
      for (int i = 0; i < N; i++) begin
        if (dr_ptr_r == AW'(i)) begin
          delta_r[i] <= DW'(bump[i]);
        end else begin
          delta_r[i] <= delta_r[i] + DW'(bump[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend_r) mem[wr_addr_r] <= dr_q_r + 32'(snap_r);
    wr_addr_r <= dr_ptr_r;
    snap_r    <= delta_r[dr_ptr_r];
    dr_q_r    <= valid_r[dr_ptr_r] ? mem[dr_ptr_r] : '0;
  end

  // Host read: memory word plus pending delta plus any snapshot whose
  // write-back lands at this same edge.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q_r  <= valid_r[req.rd_addr] ? mem[req.rd_addr] : '0;
      extra_r <= delta_r[req.rd_addr] +
                 ((wr_pend_r && wr_addr_r == req.rd_addr) ? snap_r : DW'(0));
    end
  end

  assign rd_value = rd_q_r + 32'(extra_r);

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    dr_ptr_r < AW'(N))
    else $error("drain pointer out of range");
  a_snap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> snap_r <= DW'(N))
    else $error("pending delta grew beyond one drain round");
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd_en |-> req.rd_addr < AW'(N))
    else $error("counter read address out of range");
  a_wr_follows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> wr_addr_r == $past(dr_ptr_r))
    else $error("write-back address does not follow drain read");
`endif

endmodule

[sv/ethernet_frame_classifier_stats_top.sv]
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_tvalid / in_tready   | tuser req_type, tlast last_byte,
//         |           |                         | tdata data_byte, counter_index
// out_    | output    | out_tvalid / out_tready | tuser out_kind, tdata summary
//         |           |                         | fields and read_value
//
// One item is taken per cycle while in_tready is high; a read or a frame's last byte yields a result via two registers.
// Reset (rst_n low, synchronous) clears the parser, the statistics registers,
// the counter valid bits and the pending counter deltas; no clearing pass.
// The input stalls only when both the result stage and the output register
// hold transfers that the sink has not yet taken.
module ethernet_frame_classifier_stats_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [7:0] data_byte, [12:8] counter_index, [15:13] zero
  input  logic         in_tlast,   // last_byte
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [1:0] frame_class, [4:2] l4_class, [6:5] msg_kind,
                                   // [22:7] source_port, [38:23] dest_port,
                                   // [41:39] app_class, [52:42] frame_length,
                                   // [100:53] read_value, [103:101] zero
  output logic         out_tuser   // out_kind
);

  localparam int LW = efcs_pkg::LEN_W;
  localparam int RW = efcs_pkg::RV_W;

  logic                            in_acc;
  logic                            is_read, is_byte, frame_end;
  logic [7:0]                      data_byte;
  logic [4:0]                      cidx;
  efcs_pkg::summary_t              summary;
  logic [efcs_pkg::NUM_PCOUNT-1:0] bump_raw, bump;
  efcs_pkg::ctr_req_t              creq;
  logic [31:0]                     mem_value;

  // Frame statistics that live in flip-flops.
  logic [31:0]   frame_cnt_r;
  logic [RW-1:0] byte_sum_r;
  logic [LW-1:0] max_len_r, min_len_r;

  // Result stage and output register.
  logic                 s1_v_r, s1_kind_r, s1_mem_r;
  logic [RW-1:0]        s1_val_r;
  efcs_pkg::summary_t   s1_sum_r;
  logic                 s1_go, s1_load;
  logic [RW-1:0]        rd_val;
  logic                 out_v_r, out_kind_r;
  efcs_pkg::summary_t   out_sum_r;
  logic [RW-1:0]        out_val_r;

  assign data_byte = in_tdata[7:0];
  assign cidx      = in_tdata[12:8];
  assign in_acc    = in_tvalid && in_tready;
  assign is_read   = in_acc && (in_tuser == efcs_pkg::REQ_READ);
  assign is_byte   = in_acc && (in_tuser == efcs_pkg::REQ_BYTE);
  assign frame_end = is_byte && in_tlast;

  efcs_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (is_byte),
    .data_byte (data_byte),
    .last_byte (in_tlast),
    .summary   (summary),
    .bump      (bump_raw)
  );

  assign bump = frame_end ? bump_raw : '0;

  // Protocol counters are read from memory only for their index range.
  assign creq.rd_en   = is_read && cidx >= efcs_pkg::RI_PROTO_BASE &&
                        cidx <= efcs_pkg::RI_PROTO_LAST;
  assign creq.rd_addr = efcs_pkg::PC_AW'(cidx - efcs_pkg::RI_PROTO_BASE);

  // A counter read uses the host read port of the counter memory, which is
  // registered; frame ends add to per-counter deltas that a drain reads over the
  // memory's second read port and writes back, one entry per cycle.
  efcs_counters u_counters (
    .clk      (clk),
    .rst_n    (rst_n),
    .bump     (bump),
    .req      (creq),
    .rd_value (mem_value)
  );

  // Length statistics; a minimum of zero means no frame seen yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= '0;
      byte_sum_r  <= '0;
      max_len_r   <= '0;
      min_len_r   <= '0;
    end else if (frame_end) begin
      frame_cnt_r <= frame_cnt_r + 32'd1;
      byte_sum_r  <= byte_sum_r + RW'(summary.frame_length);
      if (summary.frame_length > max_len_r) max_len_r <= summary.frame_length;
      if (summary.frame_length < min_len_r || min_len_r == '0) begin
        min_len_r <= summary.frame_length;
      end
    end
  end

  // Register-held counters are picked at the accepting edge.
  always_comb begin
    unique case (cidx)
      efcs_pkg::RI_FRAMES: rd_val = RW'(frame_cnt_r);
      efcs_pkg::RI_BYTES:  rd_val = byte_sum_r;
      efcs_pkg::RI_MAX:    rd_val = RW'(max_len_r);
      efcs_pkg::RI_MIN:    rd_val = RW'(min_len_r);
      default:             rd_val = '0;
    endcase
  end

  // The result stage moves on when the output register is empty or drains.
  // Because a new read is only taken when the stage moves, the memory's read
  // register holds its word for as long as the stage waits.
  assign s1_go     = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_go;
  assign s1_load   = is_read || frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      if (is_read) begin
        s1_kind_r <= efcs_pkg::KIND_COUNTER;
        s1_mem_r  <= creq.rd_en;
        s1_val_r  <= rd_val;
        s1_sum_r  <= '0;
      end else begin
        s1_kind_r <= efcs_pkg::KIND_SUMMARY;
        s1_mem_r  <= 1'b0;
        s1_val_r  <= '0;
        s1_sum_r  <= summary;
      end
    end
    if (s1_go && s1_v_r) begin
      out_kind_r <= s1_kind_r;
      out_sum_r  <= s1_sum_r;
      out_val_r  <= s1_mem_r ? RW'(mem_value) : s1_val_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'b000, out_val_r, out_sum_r.frame_length, out_sum_r.app_class,
                       out_sum_r.dest_port, out_sum_r.source_port, out_sum_r.msg_kind,
                       out_sum_r.l4_class, out_sum_r.frame_class};

endmodule
